// ===== src/fqs_pkg.sv =====
package fqs_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam int OPCODE_W      = 3;
    localparam int VALUE_W       = 32;
    localparam int STATUS_W      = 2;

    localparam logic [OPCODE_W-1:0] OP_ENQ    = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_DEQ    = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_PEEK   = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_LIST   = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_MINMAX = 3'd4;
    localparam logic [OPCODE_W-1:0] OP_FIND   = 3'd5;

    localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd2;

    // Selects which values go into the output word.
    localparam int RES_SEL_W = 3;
    localparam logic [RES_SEL_W-1:0] RES_PLAIN  = 3'd0;
    localparam logic [RES_SEL_W-1:0] RES_DEQ    = 3'd1;
    localparam logic [RES_SEL_W-1:0] RES_PEEK   = 3'd2;
    localparam logic [RES_SEL_W-1:0] RES_LIST   = 3'd3;
    localparam logic [RES_SEL_W-1:0] RES_MINMAX = 3'd4;
    localparam logic [RES_SEL_W-1:0] RES_FIND   = 3'd5;

    typedef struct packed {
        logic                 load_cmd;
        logic                 rd_en;
        logic                 rd_rear;
        logic                 scan_start;
        logic                 scan_step;
        logic                 acc_update;
        logic                 hold_first;
        logic                 enq_write;
        logic                 deq_pop;
        logic                 out_load;
        logic [RES_SEL_W-1:0] res_sel;
        logic [STATUS_W-1:0]  res_status;
        logic                 res_last;
    } fqs_cmd_t;

    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        logic                empty;
        logic                full;
        logic                scan_first;
        logic                scan_last;
        logic                out_free;
    } fqs_sts_t;

endpackage

// ===== src/fqs_ram.sv =====
module fqs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== src/fqs_ctrl.sv =====
module fqs_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  fqs_pkg::fqs_sts_t sts,
    output fqs_pkg::fqs_cmd_t cmd
);

    import fqs_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_READ = 3'd2;
    localparam logic [2:0] S_DATA = 3'd3;
    localparam logic [2:0] S_EMIT = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        cmd        = '0;
        cmd.res_sel    = RES_PLAIN;
        cmd.res_status = STAT_OK;
        cmd.res_last   = 1'b1;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_cmd = 1'b1;
                    state_next   = S_EXEC;
                end
            end
            S_EXEC:
            begin
                unique case (sts.opcode)
                    OP_ENQ:
                    begin
                        if (sts.out_free)
                        begin
                            cmd.out_load   = 1'b1;
                            cmd.enq_write  = !sts.full;
                            cmd.res_status = sts.full ? STAT_FULL : STAT_OK;
                            state_next     = S_IDLE;
                        end
                    end
                    OP_DEQ, OP_PEEK, OP_LIST, OP_MINMAX, OP_FIND:
                    begin
                        if (!sts.empty)
                        begin
                            cmd.scan_start = 1'b1;
                            state_next     = S_READ;
                        end
                        else if (sts.out_free)
                        begin
                            // An empty find is a plain count of zero.
                            cmd.out_load   = 1'b1;
                            cmd.res_status = (sts.opcode == OP_FIND) ? STAT_OK : STAT_EMPTY;
                            state_next     = S_IDLE;
                        end
                    end
                    default:
                    begin
                        if (sts.out_free)
                        begin
                            cmd.out_load = 1'b1;
                            state_next   = S_IDLE;
                        end
                    end
                endcase
            end
            S_READ:
            begin
                cmd.rd_en   = 1'b1;
                // The second read of a peek goes to the rear entry.
                cmd.rd_rear = (sts.opcode == OP_PEEK) && !sts.scan_first;
                state_next  = S_DATA;
            end
            S_DATA:
            begin
                unique case (sts.opcode)
                    OP_DEQ:
                    begin
                        if (sts.out_free)
                        begin
                            cmd.out_load = 1'b1;
                            cmd.res_sel  = RES_DEQ;
                            cmd.deq_pop  = 1'b1;
                            state_next   = S_IDLE;
                        end
                    end
                    OP_PEEK:
                    begin
                        if (sts.scan_first)
                        begin
                            cmd.hold_first = 1'b1;
                            cmd.scan_step  = 1'b1;
                            state_next     = S_READ;
                        end
                        else if (sts.out_free)
                        begin
                            cmd.out_load = 1'b1;
                            cmd.res_sel  = RES_PEEK;
                            state_next   = S_IDLE;
                        end
                    end
                    OP_LIST:
                    begin
                        if (sts.out_free)
                        begin
                            cmd.out_load  = 1'b1;
                            cmd.res_sel   = RES_LIST;
                            cmd.res_last  = sts.scan_last;
                            cmd.scan_step = 1'b1;
                            state_next    = sts.scan_last ? S_IDLE : S_READ;
                        end
                    end
                    OP_MINMAX, OP_FIND:
                    begin
                        cmd.acc_update = 1'b1;
                        cmd.scan_step  = 1'b1;
                        state_next     = sts.scan_last ? S_EMIT : S_READ;
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.res_sel  = (sts.opcode == OP_FIND) ? RES_FIND : RES_MINMAX;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== src/fqs_dp.sv =====
module fqs_dp #(
    parameter int DEPTH = 16,
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  fqs_pkg::fqs_cmd_t                   cmd,
    output fqs_pkg::fqs_sts_t                   sts,
    input  logic [fqs_pkg::OPCODE_W-1:0]        opcode,
    input  logic signed [fqs_pkg::VALUE_W-1:0]  value,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [fqs_pkg::STATUS_W-1:0]        status,
    output logic signed [fqs_pkg::VALUE_W-1:0]  first_value,
    output logic signed [fqs_pkg::VALUE_W-1:0]  second_value,
    output logic [CNT_W-1:0]                    match_count,
    output logic [CNT_W-1:0]                    occupancy,
    output logic                                last
);

    import fqs_pkg::*;

    localparam int IDX_W = $clog2(DEPTH);
    localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(DEPTH - 1);

    function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] pos);
        ring_next = (pos == IDX_MAX) ? '0 : pos + 1'b1;
    endfunction

    // Queue state.
    logic [IDX_W-1:0] head_reg, head_next;
    logic [IDX_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0] count_reg, count_next;

    // Latched command.
    logic [OPCODE_W-1:0]       op_reg;
    logic signed [VALUE_W-1:0] key_reg;

    // Scan state and accumulators.
    logic [IDX_W-1:0]          pos_reg;
    logic [CNT_W-1:0]          idx_reg;
    logic signed [VALUE_W-1:0] hi_reg, lo_reg, hold_reg;
    logic [CNT_W-1:0]          match_reg;

    logic                      out_valid_reg, out_valid_next;
    logic                      out_free;
    logic [IDX_W-1:0]          rear;
    logic [IDX_W-1:0]          rd_addr;
    logic signed [VALUE_W-1:0] rd_data;

    fqs_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (cmd.enq_write),
        .wr_addr (tail_reg),
        .wr_data (key_reg),
        .rd_en   (cmd.rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign rear    = (tail_reg == '0) ? IDX_MAX : tail_reg - 1'b1;
    assign rd_addr = cmd.rd_rear ? rear : pos_reg;

    assign out_free = !out_valid_reg || !out_stall;

    assign sts.opcode     = op_reg;
    assign sts.empty      = (count_reg == '0);
    assign sts.full       = (count_reg == CNT_W'(DEPTH));
    assign sts.scan_first = (idx_reg == '0);
    assign sts.scan_last  = (idx_reg == count_reg - 1'b1);
    assign sts.out_free   = out_free;

    always_comb
    begin
        head_next  = cmd.deq_pop ? ring_next(head_reg) : head_reg;
        tail_next  = cmd.enq_write ? ring_next(tail_reg) : tail_reg;
        count_next = count_reg;
        if (cmd.enq_write)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (cmd.deq_pop)
        begin
            count_next = count_reg - 1'b1;
        end
        out_valid_next = cmd.out_load ? 1'b1 : (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_cmd)
        begin
            op_reg  <= opcode;
            key_reg <= value;
        end
        if (cmd.scan_start)
        begin
            pos_reg   <= head_reg;
            idx_reg   <= '0;
            match_reg <= '0;
        end
        else if (cmd.scan_step)
        begin
            pos_reg <= ring_next(pos_reg);
            idx_reg <= idx_reg + 1'b1;
        end
        if (cmd.acc_update)
        begin
            if (idx_reg == '0 || rd_data > hi_reg)
            begin
                hi_reg <= rd_data;
            end
            if (idx_reg == '0 || rd_data < lo_reg)
            begin
                lo_reg <= rd_data;
            end
            if (rd_data == key_reg)
            begin
                match_reg <= match_reg + 1'b1;
            end
        end
        if (cmd.hold_first)
        begin
            hold_reg <= rd_data;
        end
    end

    // Output word register.
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            status       <= cmd.res_status;
            occupancy    <= count_next;
            last         <= cmd.res_last;
            first_value  <= '0;
            second_value <= '0;
            match_count  <= '0;
            unique case (cmd.res_sel)
                RES_DEQ, RES_LIST:
                begin
                    first_value <= rd_data;
                end
                RES_PEEK:
                begin
                    first_value  <= hold_reg;
                    second_value <= rd_data;
                end
                RES_MINMAX:
                begin
                    first_value  <= hi_reg;
                    second_value <= lo_reg;
                end
                RES_FIND:
                begin
                    match_count <= match_reg;
                end
                default:
                begin
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// ===== src/fifo_queue_with_scan.sv =====
// Channel  Handshake                 Word
// -------  ------------------------  ------------------------------------------------
// in       in_valid / in_stall       opcode, value
// out      out_valid / out_stall     status, first_value, second_value, match_count,
//                                    occupancy, last
//
// A command is accepted while idle and then executed; enqueue, empty-queue
// commands and unused opcodes finish in the execute state, dequeue reads and then
// pops its entry, and peek reads the front entry and then the rear one. List, min/max
// and find walk the ring store through its single registered read port, entry by
// entry; list emits a word per entry, and min/max and find emit their result at the end.
// Reset clears the head, tail and count; the store itself is never cleared.
// A stalled output word holds; the block keeps working until it needs the output
// register again, and accepts a new command whenever its controller is idle.
module fifo_queue_with_scan #(
    parameter int DEPTH = fqs_pkg::DEPTH_DEFAULT,
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [fqs_pkg::OPCODE_W-1:0]        opcode,
    input  logic signed [fqs_pkg::VALUE_W-1:0]  value,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [fqs_pkg::STATUS_W-1:0]        status,
    output logic signed [fqs_pkg::VALUE_W-1:0]  first_value,
    output logic signed [fqs_pkg::VALUE_W-1:0]  second_value,
    output logic [CNT_W-1:0]                    match_count,
    output logic [CNT_W-1:0]                    occupancy,
    output logic                                last
);

    import fqs_pkg::*;

    // The controller sequences each command; the datapath owns the ring store,
    // the head and tail pointers, the scan accumulators and the output register.
    fqs_cmd_t cmd;
    fqs_sts_t sts;

    fqs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    fqs_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .opcode       (opcode),
        .value        (value),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .first_value  (first_value),
        .second_value (second_value),
        .match_count  (match_count),
        .occupancy    (occupancy),
        .last         (last)
    );

endmodule

// ===== bench/fifo_queue_with_scan_tb.sv =====
module fifo_queue_with_scan_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import fqs_pkg::*;

    localparam int DEPTH = DEPTH_DEFAULT;
    localparam int CNT_W = $clog2(DEPTH + 1);

    // Opcodes 6 and 7 are not commands. The block must still answer each of
    // them with a single word whose status and values are all zero, and leave the queue as it was.
    localparam logic [OPCODE_W-1:0] OP_SPARE_6 = 3'd6;
    localparam logic [OPCODE_W-1:0] OP_SPARE_7 = 3'd7;

    localparam logic [VALUE_W-1:0] INT_MIN = 32'h8000_0000;
    localparam logic [VALUE_W-1:0] INT_MAX = 32'h7fff_ffff;

    localparam int RANDOM_ITEMS = 404;

    // Cycles to let pass after the last expected word, enough for a whole-store scan and more.
    localparam int DRAIN_CYCLES = 2 * DEPTH + 10;

    // One output word as the block should present it.
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [VALUE_W-1:0]  first;
        logic [VALUE_W-1:0]  second;
        logic [CNT_W-1:0]    match_cnt;
        logic [CNT_W-1:0]    occupancy;
        logic                last;
    } reply_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       in_valid = 1'b0;
    logic                       in_stall;
    logic [OPCODE_W-1:0]        opcode = OP_ENQ;
    logic signed [VALUE_W-1:0]  value = '0;
    logic                       out_valid;
    logic                       out_stall = 1'b0;
    logic [STATUS_W-1:0]        status;
    logic signed [VALUE_W-1:0]  first_value;
    logic signed [VALUE_W-1:0]  second_value;
    logic [CNT_W-1:0]           match_count;
    logic [CNT_W-1:0]           occupancy;
    logic                       last;

    // Shadow copy of the queue. Only occupied slots are ever read, which
    // keeps both the shadow and the block away from slots never written.
    logic [VALUE_W-1:0] ring_words [DEPTH];
    int                 head_pos = 0;
    int                 tail_pos = 0;
    int                 fill = 0;

    // Words that accepted commands are still owed, oldest first.
    reply_t replies_due [$];
    int     mismatch_count = 0;

    // When low, both sides run flat out: no input gaps, no output stalls.
    bit     gaps_on = 1'b1;

    fifo_queue_with_scan #(
        .DEPTH(DEPTH)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .opcode      (opcode),
        .value       (value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .first_value (first_value),
        .second_value(second_value),
        .match_count (match_count),
        .occupancy   (occupancy),
        .last        (last)
    );

    always #1 clk = ~clk;

    // The receiver stalls at random about a third of the time. Changing the
    // stall at the falling edge keeps it stable around each rising edge.
    always @(negedge clk)
    begin
        out_stall <= gaps_on && ($urandom_range(99) < 32);
    end

    // Queue one expected word. Occupancy is always the count after the
    // command, so it is read from the shadow state at the time of the call.
    function automatic void push_reply(input logic [STATUS_W-1:0] st,
                                       input logic [VALUE_W-1:0] first,
                                       input logic [VALUE_W-1:0] second,
                                       input logic [CNT_W-1:0] match_cnt,
                                       input logic fin);
        reply_t r;
        r.status    = st;
        r.first     = first;
        r.second    = second;
        r.match_cnt = match_cnt;
        r.occupancy = CNT_W'(fill);
        r.last      = fin;
        replies_due.push_back(r);
    endfunction

    // Apply one accepted command to the shadow queue and queue every word it
    // must produce. Fields without meaning for a command are expected as zero.
    function automatic void apply_queue_command(input logic [OPCODE_W-1:0] op,
                                                input logic [VALUE_W-1:0] key);
        logic signed [VALUE_W-1:0] hi;
        logic signed [VALUE_W-1:0] lo;
        logic signed [VALUE_W-1:0] item;
        logic [VALUE_W-1:0]        popped;
        int                        hits;
        case (op)
            OP_ENQ:
            begin
                if (fill == DEPTH)
                begin
                    push_reply(STAT_FULL, '0, '0, '0, 1'b1);
                end
                else
                begin
                    ring_words[tail_pos] = key;
                    tail_pos = (tail_pos + 1) % DEPTH;
                    fill++;
                    push_reply(STAT_OK, '0, '0, '0, 1'b1);
                end
            end
            OP_DEQ:
            begin
                if (fill == 0)
                begin
                    push_reply(STAT_EMPTY, '0, '0, '0, 1'b1);
                end
                else
                begin
                    popped = ring_words[head_pos];
                    head_pos = (head_pos + 1) % DEPTH;
                    fill--;
                    push_reply(STAT_OK, popped, '0, '0, 1'b1);
                end
            end
            OP_PEEK:
            begin
                if (fill == 0)
                    push_reply(STAT_EMPTY, '0, '0, '0, 1'b1);
                else
                    push_reply(STAT_OK, ring_words[head_pos],
                               ring_words[(tail_pos + DEPTH - 1) % DEPTH], '0, 1'b1);
            end
            OP_LIST:
            begin
                // One word per stored entry, front to rear; an empty queue
                // still gets a single word so the command is answered.
                if (fill == 0)
                    push_reply(STAT_EMPTY, '0, '0, '0, 1'b1);
                for (int i = 0; i < fill; i++)
                    push_reply(STAT_OK, ring_words[(head_pos + i) % DEPTH], '0, '0,
                               i == fill - 1);
            end
            OP_MINMAX:
            begin
                if (fill == 0)
                begin
                    push_reply(STAT_EMPTY, '0, '0, '0, 1'b1);
                end
                else
                begin
                    hi = ring_words[head_pos];
                    lo = hi;
                    for (int i = 1; i < fill; i++)
                    begin
                        item = ring_words[(head_pos + i) % DEPTH];
                        if (item > hi)
                            hi = item;
                        if (item < lo)
                            lo = item;
                    end
                    push_reply(STAT_OK, hi, lo, '0, 1'b1);
                end
            end
            OP_FIND:
            begin
                // Find on an empty queue is not an error: it counts zero.
                hits = 0;
                for (int i = 0; i < fill; i++)
                    if (ring_words[(head_pos + i) % DEPTH] == key)
                        hits++;
                push_reply(STAT_OK, '0, '0, CNT_W'(hits), 1'b1);
            end
            default:
            begin
                push_reply(STAT_OK, '0, '0, '0, 1'b1);
            end
        endcase
    endfunction

    // Present one command word and hold it until the block takes it. Random
    // idle cycles go in front of the word so gaps land at every point of the
    // block's work. The prediction is made at the edge where it is accepted.
    task automatic send_command(input logic [OPCODE_W-1:0] op,
                                input logic [VALUE_W-1:0] key);
        while (gaps_on && $urandom_range(99) < 32)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid <= 1'b1;
        opcode   <= op;
        value    <= key;
        do
            @(posedge clk);
        while (in_stall);
        apply_queue_command(op, key);
    endtask

    // Values weighted toward the interesting ones: extremes, small numbers
    // around zero that repeat often, and full-range values of either sign.
    function automatic logic [VALUE_W-1:0] random_value();
        case ($urandom_range(4))
            0: return $urandom;
            1: return 32'($urandom_range(6)) - 32'd3;
            2: return $urandom_range(1) ? INT_MIN : INT_MAX;
            3: return {1'b1, 31'($urandom)};
            default: return {1'b0, 31'($urandom)};
        endcase
    endfunction

    // Every command but enqueue against an empty queue, plus both unused opcodes.
    task automatic test_empty_queue();
        send_command(OP_DEQ, '0);
        send_command(OP_PEEK, '0);
        send_command(OP_LIST, '0);
        send_command(OP_MINMAX, '0);
        send_command(OP_FIND, '0);
        send_command(OP_SPARE_6, INT_MAX);
        send_command(OP_SPARE_7, INT_MIN);
    endtask

    // Fill the queue with extreme and repeated values, push once more into
    // the full queue, then scan it completely in each of the three ways.
    task automatic test_fill_to_full();
        logic [VALUE_W-1:0] fill_words [16] = '{
            INT_MIN, INT_MAX, 32'd0, 32'hffff_ffff, 32'd1, INT_MIN + 32'd1,
            INT_MAX - 32'd1, 32'h5555_5555, 32'haaaa_aaaa, 32'd7, 32'd7,
            32'hffff_fff9, 32'd7, 32'h0000_8000, 32'hffff_0000, 32'd2
        };
        for (int i = 0; i < DEPTH; i++)
            send_command(OP_ENQ, fill_words[i % 16]);
        send_command(OP_ENQ, 32'h1234_5678);
        send_command(OP_MINMAX, '0);
        send_command(OP_FIND, 32'd7);
        send_command(OP_LIST, '0);
    endtask

    // Random traffic. The mix of enqueues and dequeues drifts between
    // filling, draining and balanced spells, so the occupancy sweeps its
    // whole range and the ring indexes wrap many times. A middle stretch
    // runs with no gaps on either side.
    task automatic test_random_traffic();
        int                  bias;
        int                  pick;
        int                  enq_share;
        int                  deq_share;
        logic [OPCODE_W-1:0] op;
        logic [VALUE_W-1:0]  key;
        bias = 2;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            gaps_on = !(n >= 150 && n < 250);
            if (n % 40 == 0)
                bias = $urandom_range(2);
            enq_share = (bias == 0) ? 55 : (bias == 1) ? 15 : 35;
            deq_share = (bias == 0) ? 10 : (bias == 1) ? 45 : 25;
            pick = $urandom_range(99);
            if (pick < 3)
                op = OPCODE_W'($urandom_range(7));
            else if (pick < 3 + enq_share)
                op = OP_ENQ;
            else if (pick < 3 + enq_share + deq_share)
                op = OP_DEQ;
            else
                case ($urandom_range(3))
                    0: op = OP_PEEK;
                    1: op = OP_LIST;
                    2: op = OP_MINMAX;
                    default: op = OP_FIND;
                endcase
            // Half the find keys are taken from the queue so counts above
            // zero come up often.
            if (op == OP_FIND && fill > 0 && $urandom_range(1))
                key = ring_words[(head_pos + $urandom_range(fill - 1)) % DEPTH];
            else
                key = random_value();
            send_command(op, key);
        end
        gaps_on = 1'b1;
    endtask

    function automatic void check_field(input string name, input logic [VALUE_W-1:0] want,
                                        input logic [VALUE_W-1:0] got);
        if (want !== got)
        begin
            $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    // Every word the block hands over is compared field by field with the
    // oldest word still owed.
    always @(posedge clk)
    begin : check_replies
        reply_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (replies_due.size() == 0)
            begin
                $display("%0t ns: output word with none expected, status %h first %h",
                         $time, status, first_value);
                mismatch_count++;
            end
            else
            begin
                want = replies_due.pop_front();
                check_field("status", want.status, status);
                check_field("first_value", want.first, first_value);
                check_field("second_value", want.second, second_value);
                check_field("match_count", want.match_cnt, match_count);
                check_field("occupancy", want.occupancy, occupancy);
                check_field("last", want.last, last);
            end
        end
    end

    initial
    begin
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_empty_queue();
        test_fill_to_full();
        test_random_traffic();

        @(negedge clk);
        in_valid <= 1'b0;

        // Wait for every owed word, then a little longer so that any stray
        // extra word the block might still emit is caught.
        while (replies_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && replies_due.size() == 0)
            $display("fifo_queue_with_scan regression: pass");
        else
            $display("fifo_queue_with_scan regression: fail");
        $finish;
    end

    // Watchdog for a hung handshake; far beyond the slowest correct run.
    initial
    begin
        #1_000_000;
        $display("fifo_queue_with_scan regression: fail");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/fqs_pkg.sv
src/fqs_ram.sv
src/fqs_ctrl.sv
src/fqs_dp.sv
src/fifo_queue_with_scan.sv
bench/fifo_queue_with_scan_tb.sv
